@@ rtl/demand_paging_lru_mmu_macros.svh @@
// Assertion macros used by dplm_ctrl of the demand-paging MMU RTL.
// Expect signals named clk and rst_n in the scope of each use.
`ifndef DEMAND_PAGING_LRU_MMU_MACROS_SVH
`define DEMAND_PAGING_LRU_MMU_MACROS_SVH
`ifndef SYNTHESIS
`define DPLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DPLM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DPLM_ASSERT(lbl, prop, msg)
`define DPLM_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/dplm_pkg.sv @@
// Types, widths and status codes of the demand-paging MMU.
// Used by every module of the block; depends on nothing.
package dplm_pkg;

    localparam int NUM_PROCS_DEF      = 4;
    localparam int PAGES_PER_PROC_DEF = 64;
    localparam int MAX_FRAMES_DEF     = 256;

    localparam int STAMP_W = 32;
    localparam int FRAME_W = 8;
    localparam int CFG_W   = 9;

    localparam logic [CFG_W-1:0] FRAMES_AVAIL_RST = 9'd256;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_FREE      = 3'd1,
        ST_EVICT     = 3'd2,
        ST_INVALID   = 3'd3,
        ST_UNHANDLED = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0] proc_index;
        logic [7:0] page_number;
        logic [6:0] page_limit;
    } req_t;

    typedef struct packed {
        status_t            access_status;
        logic [FRAME_W-1:0] frame_number;
        logic               fault_handled;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

@@ rtl/demand_paging_lru_mmu.sv @@
// Demand-paging MMU with per-process LRU replacement. After reset the page table is swept
// clear, one entry a cycle, and no access is taken meanwhile; frames_available writes are
// taken at any time. The table lives in one single-port-write, single-port-read memory,
// so each access is a sequence of reads and writes on it. An invalid page goes from
// S_CHECK straight to S_EMIT; a hit or a free-frame fault passes S_CHECK, S_LOOKUP and
// then S_EMIT. A fault with no free frame scans every entry of the process through the
// read port, one a cycle, then goes through S_EVICT and S_INSTALL to S_EMIT, or straight
// to S_EMIT with an unhandled result if the process holds no valid page.
// Results go to an output register; a new access is taken while the last result waits.
// Depends on dplm_pkg, dplm_ctrl and dplm_table.
module demand_paging_lru_mmu #(
    parameter int NUM_PROCS      = dplm_pkg::NUM_PROCS_DEF,
    parameter int PAGES_PER_PROC = dplm_pkg::PAGES_PER_PROC_DEF,
    parameter int MAX_FRAMES     = dplm_pkg::MAX_FRAMES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  dplm_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output dplm_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dplm_pkg::CFG_W-1:0] cfg_data
);
    import dplm_pkg::*;

    localparam int TABLE_SIZE = NUM_PROCS * PAGES_PER_PROC;
    localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    logic [CFG_W-1:0]  frames_avail_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic              res_valid;
    logic              res_ready;
    rsp_t              res;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    assign cfg_ready = 1'b1;
    assign res_ready = !rsp_valid_reg || rsp_ready;

    dplm_ctrl #(
        .NUM_PROCS      (NUM_PROCS),
        .PAGES_PER_PROC (PAGES_PER_PROC),
        .MAX_FRAMES     (MAX_FRAMES)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req              (req),
        .frames_available (frames_avail_reg),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data)
    );

    dplm_table #(
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_avail_reg <= FRAMES_AVAIL_RST;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                frames_avail_reg <= cfg_data;
            end
            if (res_valid && res_ready)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the transaction completes
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/dplm_table.sv @@
// Page table memory: one write port, one read port, registered read data.
// Depends on dplm_pkg for the entry type.
module dplm_table #(
    parameter int   DEPTH  = 256,
    localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  dplm_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output dplm_pkg::entry_t     rd_data
);
    import dplm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/dplm_ctrl.sv @@
// Access sequencer: clearing pass, lookup, free-frame fault, victim scan, eviction.
// Depends on dplm_pkg, dplm_table timing and demand_paging_lru_mmu_macros.svh.
`include "demand_paging_lru_mmu_macros.svh"
module dplm_ctrl #(
    parameter int  NUM_PROCS      = dplm_pkg::NUM_PROCS_DEF,
    parameter int  PAGES_PER_PROC = dplm_pkg::PAGES_PER_PROC_DEF,
    parameter int  MAX_FRAMES     = dplm_pkg::MAX_FRAMES_DEF,
    localparam int TABLE_SIZE     = NUM_PROCS * PAGES_PER_PROC,
    localparam int ADDR_W         = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  dplm_pkg::req_t             req,
    input  logic [dplm_pkg::CFG_W-1:0] frames_available,
    output logic                       res_valid,
    input  logic                       res_ready,
    output dplm_pkg::rsp_t             res,
    output logic                       rd_en,
    output logic [ADDR_W-1:0]          rd_addr,
    input  dplm_pkg::entry_t           rd_data,
    output logic                       wr_en,
    output logic [ADDR_W-1:0]          wr_addr,
    output dplm_pkg::entry_t           wr_data
);
    import dplm_pkg::*;

    localparam int PG_W   = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;
    localparam int PROC_W = ($clog2(NUM_PROCS + 1) > 2) ? $clog2(NUM_PROCS + 1) : 2;
    localparam int CMP_W  = ($clog2(PAGES_PER_PROC + 1) > 8) ? $clog2(PAGES_PER_PROC + 1) : 8;
    localparam int FR_W   = ($clog2(MAX_FRAMES + 1) > CFG_W) ? $clog2(MAX_FRAMES + 1) : CFG_W;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_CHECK   = 8'b0000_0100,
        S_LOOKUP  = 8'b0000_1000,
        S_SCAN    = 8'b0001_0000,
        S_EVICT   = 8'b0010_0000,
        S_INSTALL = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [STAMP_W-1:0]  clock_reg, clock_next;
    logic [CFG_W-1:0]    handed_reg, handed_next;
    req_t                req_reg, req_next;
    logic [PG_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                found_reg, found_next;
    logic [STAMP_W-1:0]  oldest_reg, oldest_next;
    logic [ADDR_W-1:0]   victim_reg, victim_next;
    logic [FRAME_W-1:0]  victim_frame_reg, victim_frame_next;
    rsp_t                res_reg, res_next;

    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   slot;
    logic [ADDR_W-1:0]   scan_addr;
    logic [CMP_W-1:0]    limit_cap;
    logic                invalid;
    logic                free_ok;
    logic                take;
    logic [STAMP_W-1:0]  clock_inc;

    always_comb
    begin
        base      = ADDR_W'(ADDR_W'(req_reg.proc_index) * ADDR_W'(PAGES_PER_PROC));
        slot      = base + ADDR_W'(req_reg.page_number);
        scan_addr = base + ADDR_W'(scan_idx_reg);
        limit_cap = (CMP_W'(req_reg.page_limit) > CMP_W'(PAGES_PER_PROC))
                    ? CMP_W'(PAGES_PER_PROC) : CMP_W'(req_reg.page_limit);
        invalid   = (PROC_W'(req_reg.proc_index) >= PROC_W'(NUM_PROCS))
                    || (CMP_W'(req_reg.page_number) >= limit_cap);
        free_ok   = (handed_reg < frames_available)
                    && (FR_W'(handed_reg) < FR_W'(MAX_FRAMES));
        take      = rd_data.valid && (!found_reg || (rd_data.stamp < oldest_reg));
        clock_inc = clock_reg + STAMP_W'(1);
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        clock_next        = clock_reg;
        handed_next       = handed_reg;
        req_next          = req_reg;
        scan_idx_next     = scan_idx_reg;
        found_next        = found_reg;
        oldest_next       = oldest_reg;
        victim_next       = victim_reg;
        victim_frame_next = victim_frame_reg;
        res_next          = res_reg;
        req_ready         = 1'b0;
        res_valid         = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = slot;
        wr_en             = 1'b0;
        wr_addr           = slot;
        wr_data           = '{valid: 1'b1, frame: rd_data.frame, stamp: clock_inc};

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = '0;
                if (clr_idx_reg == ADDR_W'(TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (invalid)
                begin
                    res_next   = '{access_status: ST_INVALID, frame_number: '0,
                                   fault_handled: 1'b0};
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                priority if (rd_data.valid)
                begin
                    wr_en      = 1'b1;
                    clock_next = clock_inc;
                    res_next   = '{access_status: ST_HIT, frame_number: rd_data.frame,
                                   fault_handled: 1'b0};
                    state_next = S_EMIT;
                end
                else if (free_ok)
                begin
                    wr_en       = 1'b1;
                    wr_data     = '{valid: 1'b1, frame: handed_reg[FRAME_W-1:0],
                                    stamp: clock_inc};
                    handed_next = handed_reg + CFG_W'(1);
                    clock_next  = clock_inc;
                    res_next    = '{access_status: ST_FREE,
                                    frame_number: handed_reg[FRAME_W-1:0],
                                    fault_handled: 1'b1};
                    state_next  = S_EMIT;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = base;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    found_next        = 1'b1;
                    oldest_next       = rd_data.stamp;
                    victim_next       = scan_addr;
                    victim_frame_next = rd_data.frame;
                end
                if (scan_idx_reg == PG_W'(PAGES_PER_PROC - 1))
                begin
                    if (found_reg || take)
                    begin
                        state_next = S_EVICT;
                    end
                    else
                    begin
                        res_next   = '{access_status: ST_UNHANDLED, frame_number: '0,
                                       fault_handled: 1'b0};
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_addr + ADDR_W'(1);
                    scan_idx_next = scan_idx_reg + PG_W'(1);
                end
            end
            S_EVICT:
            begin
                wr_en      = 1'b1;
                wr_addr    = victim_reg;
                wr_data    = '0;
                state_next = S_INSTALL;
            end
            S_INSTALL:
            begin
                wr_en      = 1'b1;
                wr_data    = '{valid: 1'b1, frame: victim_frame_reg, stamp: clock_inc};
                clock_next = clock_inc;
                res_next   = '{access_status: ST_EVICT, frame_number: victim_frame_reg,
                               fault_handled: 1'b1};
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            clock_reg   <= '0;
            handed_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            clock_reg   <= clock_next;
            handed_reg  <= handed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg          <= req_next;
        scan_idx_reg     <= scan_idx_next;
        found_reg        <= found_next;
        oldest_reg       <= oldest_next;
        victim_reg       <= victim_next;
        victim_frame_reg <= victim_frame_next;
        res_reg          <= res_next;
    end

    assign res = res_reg;

    `DPLM_ASSERT(a_handed_step, (handed_reg != $past(handed_reg)) |-> (handed_reg == $past(handed_reg) + 1'b1), "free-frame count moved by other than one")
    `DPLM_ASSERT(a_clock_src, (clock_reg != $past(clock_reg)) |-> ($past(state_reg) == S_LOOKUP || $past(state_reg) == S_INSTALL), "access clock advanced outside a served access")
    `DPLM_NEVER(a_wr_state, wr_en && (state_reg == S_IDLE || state_reg == S_CHECK || state_reg == S_SCAN || state_reg == S_EMIT), "table written in a read-only state")
    `DPLM_ASSERT(a_no_frame, res_valid && (res_reg.access_status == ST_INVALID || res_reg.access_status == ST_UNHANDLED) |-> (res_reg.frame_number == '0 && !res_reg.fault_handled), "rejected access carries a frame")
    `DPLM_ASSERT(a_victim_slot, (state_reg == S_INSTALL) |-> (wr_addr != victim_reg), "eviction installs over its own victim")

endmodule

@@ test/tb_demand_paging_lru_mmu.sv @@
// Self-checking testbench for demand_paging_lru_mmu: drives page accesses and frame-pool
// writes through valid/ready channels and checks every result against a page-table mirror.
// Depends on dplm_pkg and the demand_paging_lru_mmu RTL.
`timescale 1ns / 1ps

module tb_demand_paging_lru_mmu;

    import dplm_pkg::*;

    localparam int unsigned PROCS       = NUM_PROCS_DEF;
    localparam int unsigned PAGES       = PAGES_PER_PROC_DEF;
    localparam int unsigned FRAMES      = MAX_FRAMES_DEF;
    localparam int unsigned SLOTS       = PROCS * PAGES;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned PHASE_ITEMS = 150;
    localparam int unsigned TAIL_CYCLES = 80;

    class mmu_shadow;
        bit [CFG_W-1:0]   frames_avail;
        bit               valid_tbl [SLOTS];
        bit [FRAME_W-1:0] frame_tbl [SLOTS];
        bit [STAMP_W-1:0] stamp_tbl [SLOTS];
        bit [STAMP_W-1:0] use_clock;
        bit [CFG_W-1:0]   handed_out;
        rsp_t             pending_replies [$];
        int unsigned      errors;

        function new();
            frames_avail = FRAMES_AVAIL_RST;
            foreach (valid_tbl[i]) valid_tbl[i] = 1'b0;
            use_clock  = '0;
            handed_out = '0;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return pending_replies.size();
        endfunction

        function void note_access(req_t r);
            rsp_t           want;
            int unsigned    limit;
            int unsigned    base;
            int unsigned    slot;
            int unsigned    pool;
            int unsigned    victim;
            bit             found;
            bit [STAMP_W-1:0] oldest;
            want.access_status = ST_INVALID;
            want.frame_number  = '0;
            want.fault_handled = 1'b0;
            limit = (r.page_limit > PAGES) ? PAGES : r.page_limit;
            if (r.proc_index < PROCS && r.page_number < limit)
            begin
                base = r.proc_index * PAGES;
                slot = base + r.page_number;
                pool = (frames_avail > FRAMES) ? FRAMES : frames_avail;
                if (valid_tbl[slot])
                begin
                    use_clock++;
                    stamp_tbl[slot]    = use_clock;
                    want.access_status = ST_HIT;
                    want.frame_number  = frame_tbl[slot];
                end
                else if (handed_out < pool)
                begin
                    use_clock++;
                    valid_tbl[slot]    = 1'b1;
                    frame_tbl[slot]    = handed_out[FRAME_W-1:0];
                    stamp_tbl[slot]    = use_clock;
                    want.access_status = ST_FREE;
                    want.frame_number  = handed_out[FRAME_W-1:0];
                    want.fault_handled = 1'b1;
                    handed_out++;
                end
                else
                begin
                    found  = 1'b0;
                    victim = 0;
                    oldest = '0;
                    for (int i = 0; i < PAGES; i++)
                    begin
                        if (valid_tbl[base+i] && (!found || stamp_tbl[base+i] < oldest))
                        begin
                            found  = 1'b1;
                            oldest = stamp_tbl[base+i];
                            victim = base + i;
                        end
                    end
                    if (found)
                    begin
                        use_clock++;
                        valid_tbl[victim]  = 1'b0;
                        valid_tbl[slot]    = 1'b1;
                        frame_tbl[slot]    = frame_tbl[victim];
                        stamp_tbl[slot]    = use_clock;
                        want.access_status = ST_EVICT;
                        want.frame_number  = frame_tbl[victim];
                        want.fault_handled = 1'b1;
                    end
                    else
                    begin
                        want.access_status = ST_UNHANDLED;
                    end
                end
            end
            pending_replies.push_back(want);
        endfunction

        task report_mismatch(string what, int unsigned want, int unsigned got);
            errors++;
            $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
        endtask

        task check_reply(rsp_t got);
            rsp_t want;
            if (pending_replies.size() == 0)
            begin
                report_mismatch("result with no access outstanding", 0, int'(got));
                return;
            end
            want = pending_replies.pop_front();
            if (got.access_status !== want.access_status)
                report_mismatch("access_status", int'(want.access_status),
                                int'(got.access_status));
            if (got.frame_number !== want.frame_number)
                report_mismatch("frame_number", int'(want.frame_number),
                                int'(got.frame_number));
            if (got.fault_handled !== want.fault_handled)
                report_mismatch("fault_handled", int'(want.fault_handled),
                                int'(got.fault_handled));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    req_t             req;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_t             rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    mmu_shadow        sb;
    bit               idle_on = 1'b1;
    int unsigned      rsp_hold_cycles = 0;
    int unsigned      cycle_count = 0;

    demand_paging_lru_mmu uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_reply(rsp);
            if (req_valid && req_ready)
                sb.note_access(req);
            if (cfg_valid && cfg_ready)
                sb.frames_avail = cfg_data;
        end
    end

    function automatic req_t mk(int unsigned p, int unsigned pg, int unsigned lim);
        req_t r;
        r.proc_index  = 2'(p);
        r.page_number = 8'(pg);
        r.page_limit  = 7'(lim);
        return r;
    endfunction

    task automatic send_access(req_t item);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_ready !== 1'b1);
    endtask

    // drop valid in the step of the last transaction, then wait for every result
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_frames(logic [CFG_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : rsp_side
        int unsigned gap;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles != 0)
            begin
                gap = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
                gap = idle_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (rsp_valid !== 1'b1);
        end
    end

    initial
    begin : stimulus
        req_t        directed [$];
        req_t        item;
        int unsigned pool;
        int unsigned pick;
        sb = new();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tiny pool so that free frames run out early
        write_frames(9'd4);
        directed.push_back(mk(0, 0, 64));
        directed.push_back(mk(0, 1, 64));
        directed.push_back(mk(0, 0, 64));
        directed.push_back(mk(1, 63, 127));
        directed.push_back(mk(1, 64, 127));
        directed.push_back(mk(2, 5, 5));
        directed.push_back(mk(3, 255, 127));
        directed.push_back(mk(3, 0, 0));
        directed.push_back(mk(3, 10, 64));
        directed.push_back(mk(2, 7, 64));
        directed.push_back(mk(0, 2, 64));
        directed.push_back(mk(1, 0, 64));
        directed.push_back(mk(3, 63, 64));
        directed.push_back(mk(0, 1, 64));
        directed.push_back(mk(0, 1, 64));
        directed.push_back(mk(3, 63, 64));
        directed.push_back(mk(2, 0, 1));
        foreach (directed[i]) send_access(directed[i]);
        settle();

        // pool lowered below the frames already handed out
        write_frames(9'd0);
        send_access(mk(0, 1, 64));
        send_access(mk(0, 5, 64));
        send_access(mk(2, 3, 64));
        send_access(mk(1, 127, 64));
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       pool = 24;
                1:       pool = 60;
                2:       pool = $urandom_range(61, 255);
                3:       pool = 256;
                4:       pool = 511;
                default: pool = 0;
            endcase
            write_frames(CFG_W'(pool));
            idle_on = (ph != 2);
            if (ph == 1)
                rsp_hold_cycles = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                item.proc_index = 2'($urandom_range(0, 3));
                if (pick < 80)
                begin
                    item.page_limit  = 7'(($urandom_range(0, 3) == 0)
                                          ? $urandom_range(1, 64) : 64);
                    item.page_number = 8'(($urandom_range(0, 1) == 0)
                                          ? $urandom_range(0, 7) : $urandom_range(0, 63));
                    if (item.page_number >= item.page_limit)
                        item.page_number = item.page_number % item.page_limit;
                end
                else
                begin
                    item.page_limit  = 7'($urandom_range(0, 127));
                    item.page_number = 8'($urandom_range(0, 255));
                end
                send_access(item);
            end
            settle();
        end

        idle_on = 1'b1;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
